### src/zbps_pkg.sv
// Shared constants, types and the shade character table of the point splat shader.
package zbps_pkg;

   // Grid geometry.
   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 32;
   localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
   localparam int COL_BITS    = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
   localparam int ROW_BITS    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
   localparam int CELL_BITS   = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   // Field widths.
   localparam int POS_WIDTH   = 24;
   localparam int EXT_WIDTH   = 16;
   localparam int VEC_WIDTH   = 16;
   localparam int DEPTH_WIDTH = 25;
   localparam int SHADE_WIDTH = 16;
   localparam int CHAR_WIDTH  = 7;
   localparam int CSR_INDEX_WIDTH = 3;

   // Cell mapping arithmetic: 25-bit position times 17-bit pitch, 16 fraction bits.
   localparam int REL_WIDTH  = POS_WIDTH + 1;
   localparam int PROD_WIDTH = REL_WIDTH + EXT_WIDTH + 1;
   localparam int MAP_SHIFT  = 16;
   localparam int Q_WIDTH    = PROD_WIDTH - MAP_SHIFT;

   // Lighting arithmetic: three Q1.14 products summed, 14 fraction bits dropped.
   localparam int TERM_WIDTH    = 2 * VEC_WIDTH;
   localparam int DOT_WIDTH     = TERM_WIDTH + 2;
   localparam int NEG_DOT_WIDTH = DOT_WIDTH + 1;
   localparam int DOT_SHIFT     = 14;
   localparam int SHADE_Q_WIDTH = NEG_DOT_WIDTH - DOT_SHIFT;
   localparam int SHADE_MAX     = 2 ** (SHADE_WIDTH - 1) - 1;
   localparam int SHADE_MIN_MAG = 2 ** (SHADE_WIDTH - 1);

   // Depth offset of 1000.0 in Q15.8.
   localparam int DEPTH_SHIFT = 256000;

   // Shade level lookup: index = (10 * shade + 10 * 16384) >> 14, clamped.
   localparam int SHADE_LEVELS    = 23;
   localparam int LEVEL_WIDTH     = 5;
   localparam int LEVEL_SUM_WIDTH = 21;
   localparam int LEVEL_OFFSET    = 10 * 16384;
   localparam int LEVEL_SHIFT     = 14;

   localparam logic [CHAR_WIDTH-1:0] SPACE_CHAR = 7'h20;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HALF_EXTENT_X = 3'd0,
      CSR_HALF_EXTENT_Y = 3'd1,
      CSR_INV_PITCH_X   = 3'd2,
      CSR_INV_PITCH_Y   = 3'd3,
      CSR_LIGHT_X       = 3'd4,
      CSR_LIGHT_Y       = 3'd5,
      CSR_LIGHT_Z       = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_CELL,
      ST_READ,
      ST_TEST,
      ST_OUT_READ,
      ST_OUT_DATA
   } state_type;

   typedef struct packed {
      logic [EXT_WIDTH-1:0] half_extent_x;
      logic [EXT_WIDTH-1:0] half_extent_y;
      logic [EXT_WIDTH-1:0] inv_pitch_x;
      logic [EXT_WIDTH-1:0] inv_pitch_y;
      logic [VEC_WIDTH-1:0] light_x;
      logic [VEC_WIDTH-1:0] light_y;
      logic [VEC_WIDTH-1:0] light_z;
   } csr_type;

   typedef struct packed {
      logic                   valid;
      logic [SHADE_WIDTH-1:0] shade;
      logic [DEPTH_WIDTH-1:0] depth;
   } cell_type;

   typedef struct packed {
      logic load;
      logic clear_write;
      logic sel_pointer;
      logic test_write;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_free;
   } status_type;

   function automatic logic [CHAR_WIDTH-1:0] shade_char(input logic [LEVEL_WIDTH-1:0] idx);
      logic [CHAR_WIDTH-1:0] ch;
      case (idx) inside
         [5'd0:5'd1]:   ch = SPACE_CHAR;
         [5'd2:5'd3]:   ch = 7'h2E;
         [5'd4:5'd6]:   ch = 7'h2C;
         [5'd7:5'd9]:   ch = 7'h2D;
         5'd10:         ch = 7'h7E;
         5'd11:         ch = 7'h3A;
         5'd12:         ch = 7'h3B;
         5'd13:         ch = 7'h3D;
         5'd14:         ch = 7'h21;
         5'd15:         ch = 7'h2A;
         [5'd16:5'd17]: ch = 7'h23;
         [5'd18:5'd19]: ch = 7'h24;
         default:       ch = 7'h40;
      endcase
      return ch;
   endfunction

endpackage

### src/zbps_ctrl.sv
// Controller state machine of the point splat shader.
module zbps_ctrl import zbps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = req_kind ? ST_OUT_READ : ST_MAP;
         end
         ST_MAP:      state_in = ST_CELL;
         ST_CELL:     state_in = ST_READ;
         ST_READ:     state_in = ST_TEST;
         ST_TEST:     state_in = ST_IDLE;
         ST_OUT_READ: state_in = ST_OUT_DATA;
         ST_OUT_DATA: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      cmd.load        = (state_ff == ST_IDLE) && req_valid;
      cmd.clear_write = (state_ff == ST_CLEAR);
      cmd.sel_pointer = (state_ff == ST_OUT_READ) || (state_ff == ST_OUT_DATA);
      cmd.test_write  = (state_ff == ST_TEST);
      cmd.emit        = (state_ff == ST_OUT_DATA) && sts.rsp_free;
   end

endmodule

### src/zbps_datapath.sv
// Datapath of the point splat shader: cell mapping, lighting, cell store and readout.
module zbps_datapath import zbps_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  sts,
   input  csr_type                     csr,
   input  logic signed [POS_WIDTH-1:0] req_vertex_x,
   input  logic signed [POS_WIDTH-1:0] req_vertex_y,
   input  logic signed [POS_WIDTH-1:0] req_vertex_z,
   input  logic signed [VEC_WIDTH-1:0] req_normal_x,
   input  logic signed [VEC_WIDTH-1:0] req_normal_y,
   input  logic signed [VEC_WIDTH-1:0] req_normal_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [CHAR_WIDTH-1:0]       rsp_shade_char,
   output logic                        rsp_end_of_row,
   output logic                        rsp_last_of_frame
);

   // Magnitude of a mapped coordinate, rounded half away from zero.
   function automatic logic [Q_WIDTH-1:0] round_mag(input logic signed [PROD_WIDTH-1:0] p);
      logic [PROD_WIDTH-1:0] mag;
      logic [PROD_WIDTH-1:0] sum;
      mag = p[PROD_WIDTH-1] ? $unsigned(-p) : $unsigned(p);
      sum = mag + (PROD_WIDTH'(1) << (MAP_SHIFT - 1));
      return sum[PROD_WIDTH-1:MAP_SHIFT];
   endfunction

   // Captured item.
   logic signed [POS_WIDTH-1:0] vx_ff, vy_ff, vz_ff;
   logic signed [VEC_WIDTH-1:0] nx_ff, ny_ff, nz_ff;

   // Map stage.
   logic signed [REL_WIDTH-1:0]   rel_x, rel_y;
   logic signed [PROD_WIDTH-1:0]  prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   logic signed [DEPTH_WIDTH-1:0] depth_in, depth_ff;
   logic signed [TERM_WIDTH-1:0]  term_x_in, term_y_in, term_z_in;
   logic signed [TERM_WIDTH-1:0]  term_x_ff, term_y_ff, term_z_ff;

   // Cell stage.
   logic [Q_WIDTH-1:0]              q_x, q_y;
   logic                            on_grid_in, on_grid_ff;
   logic [CELL_BITS-1:0]            cell_in, cell_ff;
   logic signed [DOT_WIDTH-1:0]     dot_sum;
   logic signed [NEG_DOT_WIDTH-1:0] neg_dot;
   logic [NEG_DOT_WIDTH-1:0]        neg_mag, neg_round;
   logic [SHADE_Q_WIDTH-1:0]        shade_q;
   logic [SHADE_WIDTH-1:0]          shade_in, shade_ff;

   // Cell store.
   cell_type             mem [CELL_COUNT];
   cell_type             rd_data_ff;
   cell_type             wr_data;
   logic [CELL_BITS-1:0] rd_addr, wr_addr;
   logic                 wr_en;
   logic                 depth_pass;
   logic [CELL_BITS-1:0] clear_addr_ff;

   // Readout.
   logic [CELL_BITS-1:0]              ptr_ff;
   logic [COL_BITS-1:0]               ptr_col_ff;
   logic signed [LEVEL_SUM_WIDTH-1:0] shade_ext, level_sum;
   logic [LEVEL_SUM_WIDTH-LEVEL_SHIFT-1:0] level_raw;
   logic [LEVEL_WIDTH-1:0]            level_idx;
   logic [CHAR_WIDTH-1:0]             char_in;
   logic                              ptr_last, ptr_row_end;
   logic                              rsp_valid_ff;
   logic [CHAR_WIDTH-1:0]             rsp_char_ff;
   logic                              rsp_eor_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vx_ff <= req_vertex_x;
         vy_ff <= req_vertex_y;
         vz_ff <= req_vertex_z;
         nx_ff <= req_normal_x;
         ny_ff <= req_normal_y;
         nz_ff <= req_normal_z;
      end
   end

   always_comb begin
      rel_x     = REL_WIDTH'(vx_ff) + $signed({1'b0, csr.half_extent_x});
      rel_y     = REL_WIDTH'(vy_ff) + $signed({1'b0, csr.half_extent_y});
      prod_x_in = rel_x * $signed({1'b0, csr.inv_pitch_x});
      prod_y_in = rel_y * $signed({1'b0, csr.inv_pitch_y});
      depth_in  = DEPTH_WIDTH'(vz_ff) - DEPTH_WIDTH'(DEPTH_SHIFT);
      term_x_in = nx_ff * $signed(csr.light_x);
      term_y_in = ny_ff * $signed(csr.light_y);
      term_z_in = nz_ff * $signed(csr.light_z);
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      depth_ff  <= depth_in;
      term_x_ff <= term_x_in;
      term_y_ff <= term_y_in;
      term_z_ff <= term_z_in;
   end

   always_comb begin
      q_x = round_mag(prod_x_ff);
      q_y = round_mag(prod_y_ff);
      // A negative coordinate that rounds to zero still lands in the first cell.
      on_grid_in = (!prod_x_ff[PROD_WIDTH-1] || (q_x == '0)) && (q_x < Q_WIDTH'(GRID_WIDTH))
                && (!prod_y_ff[PROD_WIDTH-1] || (q_y == '0)) && (q_y < Q_WIDTH'(GRID_HEIGHT));
      cell_in = CELL_BITS'(q_y[ROW_BITS-1:0]) * CELL_BITS'(GRID_WIDTH)
              + CELL_BITS'(q_x[COL_BITS-1:0]);

      dot_sum   = DOT_WIDTH'(term_x_ff) + DOT_WIDTH'(term_y_ff) + DOT_WIDTH'(term_z_ff);
      neg_dot   = -(NEG_DOT_WIDTH'(dot_sum));
      neg_mag   = neg_dot[NEG_DOT_WIDTH-1] ? $unsigned(-neg_dot) : $unsigned(neg_dot);
      neg_round = neg_mag + (NEG_DOT_WIDTH'(1) << (DOT_SHIFT - 1));
      shade_q   = neg_round[NEG_DOT_WIDTH-1:DOT_SHIFT];
      if (!neg_dot[NEG_DOT_WIDTH-1]) begin
         shade_in = (shade_q > SHADE_Q_WIDTH'(SHADE_MAX)) ? SHADE_WIDTH'(SHADE_MAX)
                                                          : shade_q[SHADE_WIDTH-1:0];
      end else begin
         shade_in = (shade_q > SHADE_Q_WIDTH'(SHADE_MIN_MAG)) ? SHADE_WIDTH'(SHADE_MIN_MAG)
                                                              : -shade_q[SHADE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      on_grid_ff <= on_grid_in;
      cell_ff    <= cell_in;
      shade_ff   <= shade_in;
   end

   // Store access: one write port, one registered read port.
   always_comb begin
      depth_pass = ($signed(rd_data_ff.depth) >= depth_ff);
      rd_addr    = cmd.sel_pointer ? ptr_ff : cell_ff;
      wr_en      = cmd.clear_write || cmd.emit || (cmd.test_write && on_grid_ff && depth_pass);
      if (cmd.clear_write) begin
         wr_addr = clear_addr_ff;
      end else if (cmd.emit) begin
         wr_addr = ptr_ff;
      end else begin
         wr_addr = cell_ff;
      end
      wr_data = '0;
      if (cmd.test_write) begin
         wr_data.valid = 1'b1;
         wr_data.shade = shade_ff;
         wr_data.depth = depth_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_write) begin
         clear_addr_ff <= sts.clear_last ? '0 : clear_addr_ff + 1'b1;
      end
   end

   // Readout character.
   always_comb begin
      shade_ext = LEVEL_SUM_WIDTH'($signed(rd_data_ff.shade));
      level_sum = (shade_ext <<< 3) + (shade_ext <<< 1) + LEVEL_SUM_WIDTH'(LEVEL_OFFSET);
      level_raw = level_sum[LEVEL_SUM_WIDTH-1:LEVEL_SHIFT];
      if (level_sum[LEVEL_SUM_WIDTH-1]) begin
         level_idx = '0;
      end else if (level_raw > (LEVEL_SUM_WIDTH - LEVEL_SHIFT)'(SHADE_LEVELS - 1)) begin
         level_idx = LEVEL_WIDTH'(SHADE_LEVELS - 1);
      end else begin
         level_idx = level_raw[LEVEL_WIDTH-1:0];
      end
      char_in     = rd_data_ff.valid ? shade_char(level_idx) : SPACE_CHAR;
      ptr_last    = (ptr_ff == CELL_BITS'(CELL_COUNT - 1));
      ptr_row_end = (ptr_col_ff == COL_BITS'(GRID_WIDTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         ptr_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            ptr_ff       <= ptr_last ? '0 : ptr_ff + 1'b1;
            ptr_col_ff   <= ptr_row_end ? '0 : ptr_col_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff <= char_in;
         rsp_eor_ff  <= ptr_row_end;
         rsp_last_ff <= ptr_last;
      end
   end

   assign sts.clear_last  = (clear_addr_ff == CELL_BITS'(CELL_COUNT - 1));
   assign sts.rsp_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_shade_char    = rsp_char_ff;
   assign rsp_end_of_row    = rsp_eor_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

### src/zbuffer_point_splat_shader.sv
// Top level of the z-buffer point splat shader with character readout.
//
// The req_ channel carries one transaction per item. A vertex transaction (kind 0) maps
// the vertex to a grid cell, depth tests it and stores its shaded luminance; it gives no
// response. A readout transaction (kind 1) returns the next cell in raster order on the
// rsp_ channel as a shade character, with end of row and end of frame flags, and clears
// that cell. The csr_ channel writes the seven setup registers and is always ready;
// write it only while the block is idle.
// A vertex steps through the map, cell, read and test states before the next acceptance;
// the cells live in one single-port-write memory and each vertex does a registered read
// followed by a conditional write of its cell. A readout steps through a read state and
// a data state, and its response is registered as it leaves the data state. The response
// sits in an output register, so a stalled receiver holds only a further readout; when
// rsp_ready stays low the block waits in its data state until the register frees.
// After reset the block sweeps all 2048 cells of the memory clean, one cell per cycle;
// req_ready stays low during that pass while csr_ writes are still taken.
module zbuffer_point_splat_shader import zbps_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic signed [POS_WIDTH-1:0]      req_vertex_x,
   input  logic signed [POS_WIDTH-1:0]      req_vertex_y,
   input  logic signed [POS_WIDTH-1:0]      req_vertex_z,
   input  logic signed [VEC_WIDTH-1:0]      req_normal_x,
   input  logic signed [VEC_WIDTH-1:0]      req_normal_y,
   input  logic signed [VEC_WIDTH-1:0]      req_normal_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [CHAR_WIDTH-1:0]            rsp_shade_char,
   output logic                             rsp_end_of_row,
   output logic                             rsp_last_of_frame,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [EXT_WIDTH-1:0]             csr_data
);

   csr_type    csr_ff;
   cmd_type    cmd;
   status_type sts;

   // The register file accepts a write in every cycle; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.half_extent_x <= '0;
         csr_ff.half_extent_y <= '0;
         csr_ff.inv_pitch_x   <= EXT_WIDTH'(256);
         csr_ff.inv_pitch_y   <= EXT_WIDTH'(256);
         csr_ff.light_x       <= '0;
         csr_ff.light_y       <= '0;
         csr_ff.light_z       <= VEC_WIDTH'(16384);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_EXTENT_X: csr_ff.half_extent_x <= csr_data;
            CSR_HALF_EXTENT_Y: csr_ff.half_extent_y <= csr_data;
            CSR_INV_PITCH_X:   csr_ff.inv_pitch_x   <= csr_data;
            CSR_INV_PITCH_Y:   csr_ff.inv_pitch_y   <= csr_data;
            CSR_LIGHT_X:       csr_ff.light_x       <= csr_data;
            CSR_LIGHT_Y:       csr_ff.light_y       <= csr_data;
            CSR_LIGHT_Z:       csr_ff.light_z       <= csr_data;
            default:           ;
         endcase
      end
   end

   zbps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   zbps_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr               (csr_ff),
      .req_vertex_x      (req_vertex_x),
      .req_vertex_y      (req_vertex_y),
      .req_vertex_z      (req_vertex_z),
      .req_normal_x      (req_normal_x),
      .req_normal_y      (req_normal_y),
      .req_normal_z      (req_normal_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_shade_char    (rsp_shade_char),
      .rsp_end_of_row    (rsp_end_of_row),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // A response is only loaded when the output register is free or being drained.
   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.rsp_free)
      else $error("response loaded over an untaken response");

   // Every accepted transaction keeps the block busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block ready again right after accepting a transaction");

   // Reset starts the clearing pass, which holds off the request channel.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request channel ready right after reset");

   // A response appears only as the result of a readout.
   a_response_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("response valid without a readout");

endmodule

### tb/sv/zbuffer_point_splat_shader_test.sv
// Self-checking testbench for the point splat shader: grid model, random traffic, readout checks.
module zbuffer_point_splat_shader_test;
   import zbps_pkg::*;

   localparam logic KIND_SPLAT     = 1'b0;
   localparam logic KIND_READ      = 1'b1;
   localparam int   Q14_ONE        = 16384;
   localparam int   CSR_COUNT      = 7;
   localparam int   PHASES         = 6;
   localparam int   RANDOM_ITEMS   = 600;
   // A vertex keeps the block busy through its map, cell, read and test states after
   // it is taken; this wait separates the last transaction from a setup change.
   localparam int   SETTLE_CYCLES  = 10;
   // The clearing sweep after reset clears one cell per cycle with no transaction.
   localparam int   WATCHDOG_LIMIT = 4 * CELL_COUNT;

   // One request transaction, fields at the widths of the ports.
   typedef struct packed {
      logic                 kind;
      logic [POS_WIDTH-1:0] vx;
      logic [POS_WIDTH-1:0] vy;
      logic [POS_WIDTH-1:0] vz;
      logic [VEC_WIDTH-1:0] nx;
      logic [VEC_WIDTH-1:0] ny;
      logic [VEC_WIDTH-1:0] nz;
   } splat_req_type;

   // One expected response transaction.
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] glyph;
      logic                  row_end;
      logic                  frame_end;
   } cell_readout_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_kind = KIND_SPLAT;
   logic [POS_WIDTH-1:0]  req_vertex_x = '0;
   logic [POS_WIDTH-1:0]  req_vertex_y = '0;
   logic [POS_WIDTH-1:0]  req_vertex_z = '0;
   logic [VEC_WIDTH-1:0]  req_normal_x = '0;
   logic [VEC_WIDTH-1:0]  req_normal_y = '0;
   logic [VEC_WIDTH-1:0]  req_normal_z = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic [CHAR_WIDTH-1:0] rsp_shade_char;
   logic                  rsp_end_of_row;
   logic                  rsp_last_of_frame;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_HALF_EXTENT_X;
   logic [EXT_WIDTH-1:0]  csr_data = '0;

   // Copy of the setup registers as the block should hold them.
   logic [EXT_WIDTH-1:0]        cfg_half_x, cfg_half_y, cfg_inv_x, cfg_inv_y;
   logic signed [VEC_WIDTH-1:0] cfg_light_x, cfg_light_y, cfg_light_z;

   // Copy of the cell memory and the raster readout position.
   logic signed [DEPTH_WIDTH-1:0] depth_mem [CELL_COUNT];
   logic signed [SHADE_WIDTH-1:0] luma_mem [CELL_COUNT];
   bit                            filled [CELL_COUNT];
   int                            scan_ptr;

   cell_readout_type expected_cells [$];
   int               mismatches = 0;
   int               quiet_cycles = 0;
   int               gap_odds = 35;
   bit               calm = 1'b0;

   zbuffer_point_splat_shader dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_vertex_x      (req_vertex_x),
      .req_vertex_y      (req_vertex_y),
      .req_vertex_z      (req_vertex_z),
      .req_normal_x      (req_normal_x),
      .req_normal_y      (req_normal_y),
      .req_normal_z      (req_normal_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_shade_char    (rsp_shade_char),
      .rsp_end_of_row    (rsp_end_of_row),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Grid model
   // ------------------------------------------------------------------

   function automatic longint round_half_out(input longint v, input int sh);
      longint mag;
      longint q;
      mag = (v < 0) ? -v : v;
      q = (mag + (longint'(1) << (sh - 1))) >> sh;
      return (v < 0) ? -q : q;
   endfunction

   // World position to grid coordinate: shift by the half extent, scale by the
   // inverse pitch (Q8.8 times Q15.8 leaves 16 fraction bits), round.
   function automatic longint cell_coord(input logic signed [POS_WIDTH-1:0] pos,
                                         input logic [EXT_WIDTH-1:0] half,
                                         input logic [EXT_WIDTH-1:0] inv);
      return round_half_out((longint'(pos) + longint'(half)) * longint'(inv), 16);
   endfunction

   // Luminance is the negated dot product of normal and light, back to Q1.14.
   function automatic logic signed [SHADE_WIDTH-1:0] lit_shade(
         input logic signed [VEC_WIDTH-1:0] nx, ny, nz);
      longint dot;
      longint s;
      dot = longint'(nx) * longint'(cfg_light_x) + longint'(ny) * longint'(cfg_light_y)
          + longint'(nz) * longint'(cfg_light_z);
      s = round_half_out(-dot, 14);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return 16'(s);
   endfunction

   // Luminance in [-1, 1] spreads over levels 0 to 20 of the 23-level ramp; out-of-range clamps.
   function automatic logic [CHAR_WIDTH-1:0] ramp_char(input logic signed [SHADE_WIDTH-1:0] luma);
      string  ramp = "  ..,,,---~:;=!*##$$@@@";
      longint lvl;
      byte    glyph;
      lvl = longint'(luma) * 10 + 10 * Q14_ONE;
      lvl = (lvl < 0) ? 0 : (lvl >>> 14);
      if (lvl > SHADE_LEVELS - 1) lvl = SHADE_LEVELS - 1;
      glyph = ramp[int'(lvl)];
      return glyph[CHAR_WIDTH-1:0];
   endfunction

   function automatic void reset_grid_model();
      cfg_half_x  = '0;
      cfg_half_y  = '0;
      cfg_inv_x   = 16'd256;
      cfg_inv_y   = 16'd256;
      cfg_light_x = '0;
      cfg_light_y = '0;
      cfg_light_z = 16'(Q14_ONE);
      for (int i = 0; i < CELL_COUNT; i++) begin
         depth_mem[i] = '0;
         luma_mem[i]  = '0;
         filled[i]    = 1'b0;
      end
      scan_ptr = 0;
   endfunction

   function automatic void apply_setting(input csr_index_type idx, input logic [EXT_WIDTH-1:0] val);
      case (idx)
         CSR_HALF_EXTENT_X: cfg_half_x  = val;
         CSR_HALF_EXTENT_Y: cfg_half_y  = val;
         CSR_INV_PITCH_X:   cfg_inv_x   = val;
         CSR_INV_PITCH_Y:   cfg_inv_y   = val;
         CSR_LIGHT_X:       cfg_light_x = val;
         CSR_LIGHT_Y:       cfg_light_y = val;
         CSR_LIGHT_Z:       cfg_light_z = val;
         default: ;
      endcase
   endfunction

   // Applies one accepted transaction to the grid copy. A splat may write one
   // cell; a readout queues the expected response and clears its cell.
   function automatic void track_item(input splat_req_type it);
      longint           col;
      longint           row;
      longint           depth;
      int               idx;
      cell_readout_type want;
      if (it.kind == KIND_SPLAT) begin
         col = cell_coord(it.vx, cfg_half_x, cfg_inv_x);
         row = cell_coord(it.vy, cfg_half_y, cfg_inv_y);
         if (col >= 0 && col < GRID_WIDTH && row >= 0 && row < GRID_HEIGHT) begin
            idx = int'(row) * GRID_WIDTH + int'(col);
            depth = longint'($signed(it.vz)) - DEPTH_SHIFT;
            // Equal depth wins, so a repeated splat replaces the shade.
            if (longint'(depth_mem[idx]) >= depth) begin
               luma_mem[idx]  = lit_shade(it.nx, it.ny, it.nz);
               depth_mem[idx] = 25'(depth);
               filled[idx]    = 1'b1;
            end
         end
      end else begin
         want.glyph     = filled[scan_ptr] ? ramp_char(luma_mem[scan_ptr]) : SPACE_CHAR;
         want.row_end   = (scan_ptr % GRID_WIDTH) == GRID_WIDTH - 1;
         want.frame_end = scan_ptr == CELL_COUNT - 1;
         expected_cells.push_back(want);
         depth_mem[scan_ptr] = '0;
         luma_mem[scan_ptr]  = '0;
         filled[scan_ptr]    = 1'b0;
         scan_ptr = (scan_ptr + 1 == CELL_COUNT) ? 0 : scan_ptr + 1;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Position in Q15.8 that lands near the center of a given grid coordinate,
   // so that most random vertices pass the grid bounds.
   function automatic logic [POS_WIDTH-1:0] aim_coord(input int coord,
                                                      input logic [EXT_WIDTH-1:0] half,
                                                      input logic [EXT_WIDTH-1:0] inv);
      longint span;
      longint pos;
      if (inv == 0) return 24'($urandom);
      span = 65536 / longint'(inv);
      pos = (longint'(coord) * 65536) / longint'(inv) - longint'(half);
      if (span >= 3)
         pos += longint'($urandom_range(0, 32'(2 * (span / 3)))) - span / 3;
      if (pos > 8388607) pos = 8388607;
      if (pos < -8388608) pos = -8388608;
      return 24'(pos);
   endfunction

   function automatic logic [VEC_WIDTH-1:0] rand_normal();
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 2))
            0:       return 16'(Q14_ONE);
            1:       return 16'(-Q14_ONE);
            default: return '0;
         endcase
      end
      return 16'(int'($urandom_range(0, 2 * Q14_ONE)) - Q14_ONE);
   endfunction

   function automatic splat_req_type random_vertex();
      splat_req_type it;
      int            pick;
      it.kind = KIND_SPLAT;
      if ($urandom_range(0, 99) < 85) begin
         it.vx = aim_coord(int'($urandom_range(0, GRID_WIDTH + 1)) - 1, cfg_half_x, cfg_inv_x);
         it.vy = aim_coord(int'($urandom_range(0, GRID_HEIGHT + 1)) - 1, cfg_half_y, cfg_inv_y);
      end else begin
         it.vx = 24'($urandom);
         it.vy = 24'($urandom);
      end
      // Depths mostly crowd just in front of a cleared cell so that splats
      // on the same cell fight over it.
      pick = $urandom_range(0, 99);
      if (pick < 70)
         it.vz = 24'(DEPTH_SHIFT - int'($urandom_range(0, 4000)));
      else if (pick < 85)
         it.vz = 24'($urandom);
      else
         it.vz = 24'(DEPTH_SHIFT - int'($urandom_range(0, 8000000)));
      it.nx = rand_normal();
      it.ny = rand_normal();
      it.nz = rand_normal();
      return it;
   endfunction

   // Readouts and noise carry random payload bits that the block must ignore.
   function automatic splat_req_type random_payload(input logic kind);
      splat_req_type it;
      it.kind = kind;
      it.vx = 24'($urandom);
      it.vy = 24'($urandom);
      it.vz = 24'($urandom);
      it.nx = rand_normal();
      it.ny = rand_normal();
      it.nz = rand_normal();
      return it;
   endfunction

   // Sends one request transaction, with an optional idle burst in front.
   // Valid stays high after acceptance until the next call drives a new item or a drain lowers it.
   task automatic send_item(input splat_req_type it);
      if (!calm && gap_odds > 0 && $urandom_range(1, 100) <= gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= it.kind;
      req_vertex_x <= it.vx;
      req_vertex_y <= it.vy;
      req_vertex_z <= it.vz;
      req_normal_x <= it.nx;
      req_normal_y <= it.ny;
      req_normal_z <= it.nz;
      do @(posedge clock); while (!req_ready);
      track_item(it);
   endtask

   task automatic send_vertex(input int x, input int y, input int z,
                              input int nx, input int ny, input int nz);
      splat_req_type it;
      it.kind = KIND_SPLAT;
      it.vx = 24'(x);
      it.vy = 24'(y);
      it.vz = 24'(z);
      it.nx = 16'(nx);
      it.ny = 16'(ny);
      it.nz = 16'(nz);
      send_item(it);
   endtask

   task automatic send_readout();
      send_item(random_payload(KIND_READ));
   endtask

   // Writes all seven setup registers back to back; only called with no transaction in flight.
   task automatic load_setup(input logic [EXT_WIDTH-1:0] hx, hy, px, py, lx, ly, lz);
      csr_index_type        order [CSR_COUNT];
      logic [EXT_WIDTH-1:0] value [CSR_COUNT];
      order = '{CSR_HALF_EXTENT_X, CSR_HALF_EXTENT_Y, CSR_INV_PITCH_X, CSR_INV_PITCH_Y,
                CSR_LIGHT_X, CSR_LIGHT_Y, CSR_LIGHT_Z};
      value = '{hx, hy, px, py, lx, ly, lz};
      foreach (order[i]) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_data  <= value[i];
         do @(posedge clock); while (!csr_ready);
         apply_setting(order[i], value[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Stops sending, waits for every queued response, then lets the last
   // vertex finish its read-modify-write since it has no response to wait for.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int col_pos(input int c);
      return (c - GRID_WIDTH / 2) * 256;
   endfunction

   function automatic int row_pos(input int r);
      return (r - GRID_HEIGHT / 2) * 256;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // With both inverse pitches at zero every vertex lands on cell 0 whatever
   // its position, even at the extremes of the position range. The first
   // readout of the run then shows the nearer of the two splats.
   task automatic test_zero_pitch();
      load_setup(16'hFFFF, 16'hFFFF, 16'd0, 16'd0,
                 16'(Q14_ONE), 16'(-Q14_ONE), 16'(Q14_ONE));
      send_vertex(8388607, -8388608, 0, -Q14_ONE, 0, 0);
      send_vertex(-8388608, 8388607, -1, 0, 0, -Q14_ONE / 2);
      send_readout();
      drain_and_settle();
   endtask

   // Unit cells centered on the origin and a light along (-1, -1, -1), so the
   // luminance is roughly the sum of the normal components. Cells 1 to 7 of
   // the top row get the interesting cases; cells 1 to 8 are then read back.
   task automatic test_grid_basics();
      load_setup(16'((GRID_WIDTH / 2) * 256), 16'((GRID_HEIGHT / 2) * 256), 16'd256, 16'd256,
                 16'(-Q14_ONE), 16'(-Q14_ONE), 16'(-Q14_ONE));
      // Exactly half way between columns 0 and 1 rounds away from zero.
      send_vertex(col_pos(0) + 128, row_pos(0), 0, Q14_ONE, Q14_ONE, Q14_ONE);
      // Luminance far below the ramp: written, but shows the lowest level.
      send_vertex(col_pos(2), row_pos(0), 0, -Q14_ONE, -Q14_ONE, -Q14_ONE);
      // Zero luminance still marks the cell as written.
      send_vertex(col_pos(3), row_pos(0), 0, 0, 0, 0);
      // Depth test: a farther splat loses, an equal one wins.
      send_vertex(col_pos(4), row_pos(0), 0, 0, 0, Q14_ONE);
      send_vertex(col_pos(4), row_pos(0), 100, 0, 0, 0);
      send_vertex(col_pos(4), row_pos(0), 0, 0, 0, Q14_ONE / 2);
      // Just behind a cleared cell, so it is rejected and the cell stays empty.
      send_vertex(col_pos(5), row_pos(0), DEPTH_SHIFT + 1, Q14_ONE, 0, 0);
      send_vertex(col_pos(6), row_pos(0), -8388608, Q14_ONE / 4, 0, 0);
      send_vertex(col_pos(7), row_pos(0), 8388607, Q14_ONE, 0, 0);
      // Off-grid on every side: half way below column 0, half way past the
      // last column, one row past the bottom, half way above row 0.
      send_vertex(col_pos(0) - 128, row_pos(1), 0, Q14_ONE, 0, 0);
      send_vertex(col_pos(GRID_WIDTH) - 128, row_pos(1), 0, Q14_ONE, 0, 0);
      send_vertex(col_pos(1), row_pos(GRID_HEIGHT), 0, Q14_ONE, 0, 0);
      send_vertex(col_pos(1), row_pos(0) - 128, 0, Q14_ONE, 0, 0);
      repeat (8) send_readout();
      drain_and_settle();
   endtask

   // Bursts of splats followed by bursts of readouts, with some noise of
   // mixed kinds. Early phases pin the setup registers to their extremes.
   task automatic test_random_traffic(input int phase, input int count);
      int sent;
      int burst;
      case (phase)
         0: load_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'(Q14_ONE), 16'(Q14_ONE), 16'(Q14_ONE));
         1: load_setup(16'd0, 16'd0, 16'd1, 16'd1,
                       16'(-Q14_ONE), 16'(-Q14_ONE), 16'(-Q14_ONE));
         2: load_setup(16'($urandom), 16'($urandom), 16'd0, 16'($urandom_range(1, 65535)),
                       rand_normal(), rand_normal(), rand_normal());
         default:
            load_setup(16'($urandom), 16'($urandom),
                       16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                       rand_normal(), rand_normal(), rand_normal());
      endcase
      gap_odds = (phase % 3 == 2) ? 0 : 35;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               send_item(($urandom_range(0, 1) == 0) ? random_vertex()
                                                     : random_payload(KIND_READ));
            end
         end else begin
            burst = $urandom_range(1, 16);
            repeat (burst) send_item(random_vertex());
            sent += burst;
            burst = $urandom_range(1, 12);
            repeat (burst) send_readout();
         end
         sent += burst;
      end
      drain_and_settle();
   endtask

   // Reads through the end of the frame and past the wrap back to cell 0,
   // with no idling on either side.
   task automatic test_frame_wrap();
      int remaining;
      calm = 1'b1;
      load_setup(16'((GRID_WIDTH / 2) * 256), 16'((GRID_HEIGHT / 2) * 256), 16'd256, 16'd256,
                 16'd0, 16'd0, 16'(-Q14_ONE));
      send_vertex(col_pos(GRID_WIDTH - 1), row_pos(GRID_HEIGHT - 1), 0, 0, 0, Q14_ONE);
      send_vertex(col_pos(0), row_pos(0), 0, 0, 0, -Q14_ONE / 2);
      remaining = CELL_COUNT - scan_ptr + 2;
      repeat (remaining) send_readout();
      drain_and_settle();
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Receiver stalls in random bursts, with occasional long open stretches.
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 40) == 0) begin
            repeat (50) @(posedge clock);
         end
      end
   end

   // Every response transaction is matched against the oldest expected cell.
   always @(posedge clock) begin
      cell_readout_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cells.size() == 0) begin
            $error("response with nothing expected: shade_char %02h", rsp_shade_char);
            mismatches++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_shade_char !== want.glyph) begin
               $error("shade_char expected %02h got %02h", want.glyph, rsp_shade_char);
               mismatches++;
            end
            if (rsp_end_of_row !== want.row_end) begin
               $error("end_of_row expected %0b got %0b", want.row_end, rsp_end_of_row);
               mismatches++;
            end
            if (rsp_last_of_frame !== want.frame_end) begin
               $error("last_of_frame expected %0b got %0b", want.frame_end, rsp_last_of_frame);
               mismatches++;
            end
         end
      end
   end

   // The run is stuck when no transaction of any channel completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset_grid_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_zero_pitch();
      test_grid_basics();
      for (int p = 0; p < PHASES; p++) test_random_traffic(p, RANDOM_ITEMS / PHASES);
      test_frame_wrap();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
